// ----- design/pcomp_pkg.sv -----
// Package with shared types, constants and helpers for the pressure/temperature compensation block.
package pcomp_pkg;

  localparam int OpW = 5;
  localparam int DivSteps = 32;

  // Micro-operation codes, issued in ascending order within each sequence.
  localparam logic [OpW-1:0] OP_T1   = 5'd0;
  localparam logic [OpW-1:0] OP_T2   = 5'd1;
  localparam logic [OpW-1:0] OP_T3   = 5'd2;
  localparam logic [OpW-1:0] OP_T4   = 5'd3;
  localparam logic [OpW-1:0] OP_T5   = 5'd4;
  localparam logic [OpW-1:0] OP_T6   = 5'd5;
  localparam logic [OpW-1:0] OP_P1   = 5'd6;
  localparam logic [OpW-1:0] OP_P2   = 5'd7;
  localparam logic [OpW-1:0] OP_P3   = 5'd8;
  localparam logic [OpW-1:0] OP_P4   = 5'd9;
  localparam logic [OpW-1:0] OP_P5   = 5'd10;
  localparam logic [OpW-1:0] OP_P6   = 5'd11;
  localparam logic [OpW-1:0] OP_P7   = 5'd12;
  localparam logic [OpW-1:0] OP_P8   = 5'd13;
  localparam logic [OpW-1:0] OP_P9   = 5'd14;
  localparam logic [OpW-1:0] OP_P10  = 5'd15;
  localparam logic [OpW-1:0] OP_P11  = 5'd16;
  localparam logic [OpW-1:0] OP_DFIX = 5'd17;
  localparam logic [OpW-1:0] OP_C1   = 5'd18;
  localparam logic [OpW-1:0] OP_C2   = 5'd19;
  localparam logic [OpW-1:0] OP_C3   = 5'd20;
  localparam logic [OpW-1:0] OP_C4   = 5'd21;

  // Configuration register indexes.
  localparam logic [1:0] REG_TEMP_CAL = 2'd0;
  localparam logic [1:0] REG_PRESS_LO = 2'd1;
  localparam logic [1:0] REG_PRESS_HI = 2'd2;
  localparam logic [1:0] REG_PRESS_P9 = 2'd3;

  // Arithmetic constants of the compensation formulas.
  localparam logic [31:0] OFFSET_FINE = 32'd64000;
  localparam logic [31:0] RAW_FULL    = 32'd1048576;
  localparam logic [31:0] PRESS_SCALE = 32'd3125;
  localparam logic [31:0] HALF_ADD    = 32'd32768;
  localparam logic [31:0] ROUND_TEMP  = 32'd128;

  typedef struct packed {
    logic           load;
    logic           exec;
    logic [OpW-1:0] op;
    logic           div_step;
    logic           publish;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
  } status_t;

  // Signed division by 2^k that truncates toward zero.
  function automatic logic [31:0] dtz(input logic [31:0] x, input logic [4:0] k);
    logic signed [32:0] xs;
    logic signed [32:0] bias;
    logic signed [32:0] r;
    xs   = {x[31], x};
    bias = x[31] ? ((33'sd1 <<< k) - 33'sd1) : 33'sd0;
    r    = (xs + bias) >>> k;
    return r[31:0];
  endfunction

  // Sign extension of a 16-bit coefficient.
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ----- design/pcomp_dp.sv -----
// Datapath: calibration registers, working registers, shared multiplier and divider step.
module pcomp_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic [19:0]          raw_sample,
  input  pcomp_pkg::cmd_t      cmd,
  output pcomp_pkg::status_t   status,
  output logic [31:0]          temperature,
  output logic [31:0]          pressure,
  output logic                 pressure_invalid
);

  logic [47:0] temp_cal;
  logic [63:0] press_lo;
  logic [63:0] press_hi;
  logic [15:0] press_p9;
  logic [31:0] fine;

  logic [19:0] raw;
  logic [31:0] ra, rb, rc, rq, rs, rp, dq;
  logic [31:0] rem;
  logic        big;
  logic [31:0] res_temp, res_press;
  logic        res_inv;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] rawz;
  logic [31:0] mul_a, mul_b, prod;
  logic [32:0] rem_sh;
  logic        fits;

  assign t1   = {16'd0, temp_cal[15:0]};
  assign t2   = pcomp_pkg::sx16(temp_cal[31:16]);
  assign t3   = pcomp_pkg::sx16(temp_cal[47:32]);
  assign p1   = {16'd0, press_lo[15:0]};
  assign p2   = pcomp_pkg::sx16(press_lo[31:16]);
  assign p3   = pcomp_pkg::sx16(press_lo[47:32]);
  assign p4   = pcomp_pkg::sx16(press_lo[63:48]);
  assign p5   = pcomp_pkg::sx16(press_hi[15:0]);
  assign p6   = pcomp_pkg::sx16(press_hi[31:16]);
  assign p7   = pcomp_pkg::sx16(press_hi[47:32]);
  assign p8   = pcomp_pkg::sx16(press_hi[63:48]);
  assign p9   = pcomp_pkg::sx16(press_p9);
  assign rawz = {12'd0, raw};

  // Operand selection for the single shared multiplier (low 32 bits kept).
  always_comb begin
    mul_a = ra;
    mul_b = 32'd0;
    case (cmd.op)
      pcomp_pkg::OP_T2:  begin mul_a = ra; mul_b = t2; end
      pcomp_pkg::OP_T3:  begin
        mul_a = (rawz >> 4) - t1;
        mul_b = (rawz >> 4) - t1;
      end
      pcomp_pkg::OP_T4:  begin mul_a = rb; mul_b = t3; end
      pcomp_pkg::OP_T6:  begin mul_a = fine; mul_b = 32'd5; end
      pcomp_pkg::OP_P3:  begin mul_a = rq; mul_b = rq; end
      pcomp_pkg::OP_P4:  begin mul_a = pcomp_pkg::dtz(rs, 5'd11); mul_b = p6; end
      pcomp_pkg::OP_P5:  begin mul_a = ra; mul_b = p5; end
      pcomp_pkg::OP_P7:  begin mul_a = p3; mul_b = pcomp_pkg::dtz(rs, 5'd13); end
      pcomp_pkg::OP_P8:  begin mul_a = p2; mul_b = ra; end
      pcomp_pkg::OP_P9:  begin mul_a = pcomp_pkg::HALF_ADD + ra; mul_b = p1; end
      pcomp_pkg::OP_P10: begin
        mul_a = (pcomp_pkg::RAW_FULL - rawz) - pcomp_pkg::dtz(rb, 5'd12);
        mul_b = pcomp_pkg::PRESS_SCALE;
      end
      pcomp_pkg::OP_C1:  begin mul_a = rp >> 3; mul_b = rp >> 3; end
      pcomp_pkg::OP_C2:  begin mul_a = p9; mul_b = rs; end
      pcomp_pkg::OP_C3:  begin mul_a = rp >> 2; mul_b = p8; end
      default:           begin mul_a = ra; mul_b = 32'd0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // One restoring divider step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem, dq[31]};
  assign fits   = rem_sh >= {1'b0, ra};

  assign status.den_zero = (ra == 32'd0);

  // Configuration and fine temperature carry reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal <= '0;
      press_lo <= '0;
      press_hi <= '0;
      press_p9 <= '0;
      fine     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pcomp_pkg::REG_TEMP_CAL: temp_cal <= cfg_data[47:0];
          pcomp_pkg::REG_PRESS_LO: press_lo <= cfg_data;
          pcomp_pkg::REG_PRESS_HI: press_hi <= cfg_data;
          pcomp_pkg::REG_PRESS_P9: press_p9 <= cfg_data[15:0];
          default:                 press_p9 <= press_p9;
        endcase
      end
      if (cmd.exec && cmd.op == pcomp_pkg::OP_T5) begin
        fine <= ra + rb;
      end
    end
  end

  // Working registers, updated on load, by each divider step and by the issued operation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw       <= raw_sample;
      res_temp  <= '0;
      res_press <= '0;
      res_inv   <= 1'b0;
    end
    if (cmd.div_step) begin
      rem <= fits ? 32'(rem_sh - {1'b0, ra}) : rem_sh[31:0];
      dq  <= {dq[30:0], fits};
    end
    if (cmd.exec) begin
      case (cmd.op)
        pcomp_pkg::OP_T1:  ra <= (rawz >> 3) - (t1 << 1);
        pcomp_pkg::OP_T2:  ra <= pcomp_pkg::dtz(prod, 5'd11);
        pcomp_pkg::OP_T3:  rb <= pcomp_pkg::dtz(prod, 5'd12);
        pcomp_pkg::OP_T4:  rb <= pcomp_pkg::dtz(prod, 5'd14);
        pcomp_pkg::OP_T6:  res_temp <= pcomp_pkg::dtz(prod + pcomp_pkg::ROUND_TEMP, 5'd8);
        pcomp_pkg::OP_P1:  ra <= pcomp_pkg::dtz(fine, 5'd1) - pcomp_pkg::OFFSET_FINE;
        pcomp_pkg::OP_P2:  rq <= pcomp_pkg::dtz(ra, 5'd2);
        pcomp_pkg::OP_P3:  rs <= prod;
        pcomp_pkg::OP_P4:  rb <= prod;
        pcomp_pkg::OP_P5:  rb <= rb + (prod << 1);
        pcomp_pkg::OP_P6:  rb <= pcomp_pkg::dtz(rb, 5'd2) + (p4 << 16);
        pcomp_pkg::OP_P7:  rc <= pcomp_pkg::dtz(prod, 5'd3);
        pcomp_pkg::OP_P8:  ra <= pcomp_pkg::dtz(rc + pcomp_pkg::dtz(prod, 5'd1), 5'd18);
        pcomp_pkg::OP_P9:  ra <= pcomp_pkg::dtz(prod, 5'd15);
        pcomp_pkg::OP_P10: rp <= prod;
        pcomp_pkg::OP_P11: begin
          // A zero divisor ends the transaction with the invalid flag set.
          res_inv <= (ra == 32'd0);
          big     <= rp[31];
          dq      <= rp[31] ? rp : (rp << 1);
          rem     <= '0;
        end
        pcomp_pkg::OP_DFIX: rp <= big ? (dq << 1) : dq;
        pcomp_pkg::OP_C1:  rs <= prod >> 13;
        pcomp_pkg::OP_C2:  rc <= pcomp_pkg::dtz(prod, 5'd12);
        pcomp_pkg::OP_C3:  ra <= rc + pcomp_pkg::dtz(prod, 5'd13);
        pcomp_pkg::OP_C4:  res_press <= rp + pcomp_pkg::dtz(ra + p7, 5'd4);
        default:           rq <= rq;
      endcase
    end
  end

  // Output holding registers, loaded when a result is handed over.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      temperature      <= res_temp;
      pressure         <= res_press;
      pressure_invalid <= res_inv;
    end
  end

endmodule

// ----- design/pcomp_ctrl.sv -----
// Controller: sequences micro-operations, the divider steps and the result handshake.
module pcomp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  output logic                out_valid,
  input  logic                out_ready,
  input  pcomp_pkg::status_t  status,
  output pcomp_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                state, state_next;
  logic [pcomp_pkg::OpW-1:0] op, op_next;
  logic [4:0]                cnt, cnt_next;
  logic                      accept;

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign cmd.load     = accept;
  assign cmd.exec     = (state == S_CALC);
  assign cmd.op       = op;
  assign cmd.div_step = (state == S_DIV);
  assign cmd.publish  = (state == S_DONE) && (!out_valid || out_ready);

  // Next state and operation pointer.
  always_comb begin
    state_next = state;
    op_next    = op;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CALC;
          op_next    = mode ? pcomp_pkg::OP_P1 : pcomp_pkg::OP_T1;
        end
      end
      S_CALC: begin
        if (op == pcomp_pkg::OP_T6 || op == pcomp_pkg::OP_C4) begin
          state_next = S_DONE;
        end else if (op == pcomp_pkg::OP_P11) begin
          if (status.den_zero) begin
            state_next = S_DONE;
          end else begin
            state_next = S_DIV;
            cnt_next   = '0;
          end
        end else begin
          op_next = op + 5'd1;
        end
      end
      S_DIV: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(pcomp_pkg::DivSteps - 1)) begin
          state_next = S_CALC;
          op_next    = pcomp_pkg::OP_DFIX;
        end
      end
      S_DONE: begin
        if (cmd.publish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      cnt   <= cnt_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // An accepted transaction starts the operation sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CALC))
    else $error("accepted transaction did not start computing");

  // The last divider step returns to the sequencer at the quotient fix-up.
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == 5'(pcomp_pkg::DivSteps - 1)) |=>
      (state == S_CALC && op == pcomp_pkg::OP_DFIX))
    else $error("divider did not hand back after its last step");

  // A result is never loaded over one that is still pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("pending result overwritten");
`endif

endmodule

// ----- design/pressure_temperature_compensation.sv -----
// Top level of the pressure/temperature compensation block.
// Each transaction carries one 20-bit raw reading; mode 0 is temperature, mode 1 pressure.
// A temperature transaction runs operations T1 to T6 and updates the stored fine temperature;
// a pressure transaction runs P1 to P11, a bit-serial restoring divider, the quotient fix-up
// and C1 to C4, or ends after P11 when the divisor is zero. One transaction is processed
// at a time, set by the shared multiplier sequence and the bit-serial divider. The result
// sits in an output register until taken.
// Calibration writes are accepted at any time and should only occur while idle.
module pressure_temperature_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [19:0] raw_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] temperature,
  output logic [31:0] pressure,
  output logic        pressure_invalid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  pcomp_pkg::cmd_t    cmd;
  pcomp_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pcomp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pcomp_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .raw_sample       (raw_sample),
    .cmd              (cmd),
    .status           (status),
    .temperature      (temperature),
    .pressure         (pressure),
    .pressure_invalid (pressure_invalid)
  );

endmodule

// ----- tb/pressure_temperature_compensation_test.sv -----
// Self-checking testbench for the pressure and temperature compensation block.
module pressure_temperature_compensation_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] pressure;
    logic        invalid;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic [19:0] raw_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] temperature;
  logic [31:0] pressure;
  logic        pressure_invalid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Predictor state: calibration words and the kept fine temperature.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo;
  logic [63:0] cal_press_hi;
  logic [15:0] cal_p9;
  logic [31:0] fine_temp;

  reading_t expected_readings[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  pressure_temperature_compensation dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Signed divide by a power of two rounding toward zero, 32-bit wrap.
  function automatic logic signed [31:0] shr_tz(input logic signed [31:0] x, input int k);
    logic signed [63:0] v;
    v = x;
    return 32'((v < 0) ? -((-v) >>> k) : (v >>> k));
  endfunction

  function automatic logic signed [31:0] coef(input logic [63:0] v, input int sh);
    logic [15:0] b;
    b = v[sh +: 16];
    return {{16{b[15]}}, b};
  endfunction

  // Compensate one raw reading and update the kept fine temperature.
  function automatic reading_t compensate(input logic m, input logic [19:0] raw);
    reading_t r;
    logic signed [31:0] t1, t2, t3, a, b, d, tf, q, c;
    logic signed [31:0] p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, corr, sq;
    logic [31:0] p1, p, den, e, esq;
    r = '0;
    if (!m) begin
      t1 = {16'd0, cal_temp[15:0]};
      t2 = coef({16'd0, cal_temp}, 16);
      t3 = coef({16'd0, cal_temp}, 32);
      a = $signed({12'd0, raw} >> 3) - (t1 <<< 1);
      a = shr_tz(a * t2, 11);
      d = $signed({12'd0, raw} >> 4) - t1;
      b = shr_tz(d * d, 12);
      b = shr_tz(b * t3, 14);
      tf = a + b;
      fine_temp = tf;
      r.temperature = shr_tz(tf * 5 + 128, 8);
    end else begin
      p1 = {16'd0, cal_press_lo[15:0]};
      p2 = coef(cal_press_lo, 16);
      p3 = coef(cal_press_lo, 32);
      p4 = coef(cal_press_lo, 48);
      p5 = coef(cal_press_hi, 0);
      p6 = coef(cal_press_hi, 16);
      p7 = coef(cal_press_hi, 32);
      p8 = coef(cal_press_hi, 48);
      p9 = coef({48'd0, cal_p9}, 0);
      a = shr_tz(fine_temp, 1) - 64000;
      q = shr_tz(a, 2);
      b = shr_tz(q * q, 11) * p6;
      b = b + (a * p5) * 2;
      b = shr_tz(b, 2) + p4 * 65536;
      c = shr_tz(p3 * shr_tz(q * q, 13), 3);
      a = shr_tz(c + shr_tz(p2 * a, 1), 18);
      a = shr_tz((32768 + a) * $signed(p1), 15);
      p = ((32'd1048576 - {12'd0, raw}) - shr_tz(b, 12)) * 32'd3125;
      if (a == 0) begin
        r.invalid = 1'b1;
      end else begin
        den = a;
        if (p < 32'h8000_0000) p = (p << 1) / den;
        else p = (p / den) * 2;
        e = p >> 3;
        esq = e * e;
        sq = esq >> 13;
        v1 = shr_tz(p9 * sq, 12);
        v2 = shr_tz($signed(p >> 2) * p8, 13);
        corr = shr_tz(v1 + v2 + p7, 4);
        r.pressure = p + corr;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Receiver: random stalls and comparison against the oldest expectation.
  always @(posedge clk) begin
    reading_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result", temperature, 32'd0);
        end else begin
          w = expected_readings.pop_front();
          if (temperature !== w.temperature)
            report_mismatch("temperature", temperature, w.temperature);
          if (pressure !== w.pressure) report_mismatch("pressure", pressure, w.pressure);
          if (pressure_invalid !== w.invalid)
            report_mismatch("pressure_invalid", {31'd0, pressure_invalid},
                            {31'd0, w.invalid});
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Send one reading as a transaction, with a random gap first.
  task automatic send_reading(input logic m, input logic [19:0] raw);
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) in_valid <= 1'b0;
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    mode <= m;
    raw_sample <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_readings.push_back(compensate(m, raw));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pcomp_pkg::REG_TEMP_CAL: cal_temp = data[47:0];
      pcomp_pkg::REG_PRESS_LO: cal_press_lo = data;
      pcomp_pkg::REG_PRESS_HI: cal_press_hi = data;
      default:                 cal_p9 = data[15:0];
    endcase
  endtask

  task automatic load_calibration(input logic [47:0] t, input logic [63:0] lo,
                                  input logic [63:0] hi, input logic [15:0] p9);
    drain();
    write_register(pcomp_pkg::REG_TEMP_CAL, {16'd0, t});
    write_register(pcomp_pkg::REG_PRESS_LO, lo);
    write_register(pcomp_pkg::REG_PRESS_HI, hi);
    write_register(pcomp_pkg::REG_PRESS_P9, {48'd0, p9});
    cfg_valid <= 1'b0;
  endtask

  // Typical sensor calibration words.
  task automatic load_typical();
    load_calibration({16'hFFE8 + 16'd0, 16'd26435, 16'd27504},
                     {16'd2855, 16'hD0B9, 16'd8900, 16'd36477},
                     {16'hFFF9, 16'd15500, 16'hFF75, 16'd140}, 16'd6000);
  endtask

  // Directed: pressure before any temperature, field extremes, zero divisor.
  task automatic test_directed();
    send_reading(1'b1, 20'd415148);
    send_reading(1'b0, 20'd0);
    send_reading(1'b0, 20'hFFFFF);
    send_reading(1'b0, 20'd519888);
    send_reading(1'b1, 20'd0);
    send_reading(1'b1, 20'hFFFFF);
    send_reading(1'b1, 20'd415148);
    // All-zero pressure calibration forces a zero divisor.
    load_calibration(cal_temp, 64'd0, 64'd0, 16'd0);
    send_reading(1'b1, 20'd300000);
    send_reading(1'b0, 20'h55555);
    send_reading(1'b1, 20'hAAAAA);
    // Extreme calibration words.
    load_calibration({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'h8000);
    send_reading(1'b0, 20'hFFFFF);
    send_reading(1'b1, 20'hFFFFF);
    send_reading(1'b0, 20'd0);
    send_reading(1'b1, 20'd0);
    load_calibration({16'h7FFF, 16'h7FFF, 16'hFFFF}, {4{16'h7FFF}}, {4{16'h8000}}, 16'h7FFF);
    send_reading(1'b0, 20'd123456);
    send_reading(1'b1, 20'd654321);
  endtask

  // Random: mostly temperature then pressure pairs, some lone items.
  task automatic test_random(input int count, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) != 0) begin
        send_reading(1'b0, 20'($urandom_range(20'hFFFFF)));
        send_reading(1'b1, 20'($urandom_range(20'hFFFFF)));
        i++;
      end else begin
        send_reading(1'($urandom_range(1)), 20'($urandom_range(20'hFFFFF)));
      end
    end
  endtask

  task automatic test_random_calibration(input int s_idle, input int r_idle);
    load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
    test_random(50, s_idle, r_idle);
    load_typical();
    test_random(100, s_idle, r_idle);
  endtask

  initial begin
    cal_temp = '0;
    cal_press_lo = '0;
    cal_press_hi = '0;
    cal_p9 = '0;
    fine_temp = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 18;
    recv_idle_pct = 82;
    test_directed();
    load_typical();
    test_random_calibration(18, 82);
    test_random_calibration(82, 18);
    test_random_calibration(0, 0);
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
